@@ rtl/iir_lowpass_direct_form_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the IIR low-pass filter
// Shared property wrappers, clocked on aclk and quiet while reset is held.
// ----------------------------------------------------------------------------
`ifndef IIR_LOWPASS_DIRECT_FORM_DEFINES_SVH
`define IIR_LOWPASS_DIRECT_FORM_DEFINES_SVH

// Same-cycle implication
`define IIR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define IIR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/iir_lp_pkg.sv @@
// ----------------------------------------------------------------------------
// IIR low-pass filter package
// Widths, command codes and sequencer states for the direct-form-I filter.
// ----------------------------------------------------------------------------
package iir_lp_pkg;

    // Filter depth
    localparam int MAX_ORDER = 8;
    localparam int NUM_DEPTH = MAX_ORDER + 1;
    localparam int DEN_DEPTH = MAX_ORDER;
    localparam int NUM_IDX_W = $clog2(NUM_DEPTH);
    localparam int DEN_IDX_W = (DEN_DEPTH > 1) ? $clog2(DEN_DEPTH) : 1;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int TAP_W    = 4;
    localparam int COEF_W   = 32;
    localparam int OUT_W    = 32;
    localparam int ORDER_W  = 4;

    // Accumulator: Q.38 fraction, 64 bits
    localparam int ACC_W       = 64;
    localparam int NUM_SHIFT   = 14;
    localparam int ROUND_SHIFT = 24;
    localparam int QUOT_W      = ACC_W - ROUND_SHIFT;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_NUM_TAP = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DEN_TAP = 2'd2;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_NUM   = 6'b000010,
        S_DEN   = 6'b000100,
        S_DRAIN = 6'b001000,
        S_RND   = 6'b010000,
        S_OUT   = 6'b100000
    } state_t;

endpackage

@@ rtl/iir_lowpass_direct_form.sv @@
// The single shared 32x32 MAC takes the N+1 feed-forward and N feedback taps
// one per cycle (N = clamped order); a new sample is accepted only after the
// previous result has been loaded into the output register.
// Tap writes give no result. Reset (aresetn, synchronous, active low) clears
// both histories, all taps, and sets the order to 1.
// ----------------------------------------------------------------------------
// IIR low-pass filter, direct form I
// Fixed-point IIR filter with one multiplier reused across all taps,
// a saturating 64-bit accumulator, round-to-nearest and 32-bit saturation.
// ----------------------------------------------------------------------------
`include "iir_lowpass_direct_form_defines.svh"

module iir_lowpass_direct_form
    import iir_lp_pkg::*;
(
    input  logic                       aclk,
    input  logic                       aresetn,
    // configuration
    input  logic                       cfg_wr_en,
    input  logic [ORDER_W-1:0]         cfg_wr_data,
    // input channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [CMD_W-1:0]           s_command,
    input  logic signed [SAMPLE_W-1:0] s_sample,
    input  logic [TAP_W-1:0]           s_tap_index,
    input  logic signed [COEF_W-1:0]   s_coefficient,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic signed [OUT_W-1:0]    m_filtered
);

    localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) << (ROUND_SHIFT - 1);
    localparam logic signed [ACC_W-1:0] ACC_MAX    = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN    = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic signed [OUT_W-1:0] OUT_MAX    = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN    = {1'b1, {(OUT_W-1){1'b0}}};

    // Saturating add or subtract on the accumulator
    function automatic logic signed [ACC_W-1:0] sat_addsub(
        input logic signed [ACC_W-1:0] a,
        input logic signed [ACC_W-1:0] b,
        input logic                    sub
    );
        logic signed [ACC_W:0] s;
        if (sub) begin
            s = {a[ACC_W-1], a} - {b[ACC_W-1], b};
        end else begin
            s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        end
        if (s[ACC_W] != s[ACC_W-1]) begin
            return s[ACC_W] ? ACC_MIN : ACC_MAX;
        end
        return s[ACC_W-1:0];
    endfunction

    // State
    state_t                     state_reg, state_next;
    logic [ORDER_W-1:0]         order_reg;
    logic [NUM_IDX_W-1:0]       n_reg, n_next;
    logic [NUM_IDX_W-1:0]       idx_reg, idx_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic signed [ACC_W-1:0]    prod_reg;
    logic                       prod_vld_reg, prod_vld_next;
    logic                       prod_sub_reg, prod_sub_next;
    logic                       m_valid_reg, m_valid_next;
    logic signed [OUT_W-1:0]    m_filtered_reg;

    logic signed [SAMPLE_W-1:0] x_hist_reg [NUM_DEPTH];
    logic signed [OUT_W-1:0]    y_hist_reg [DEN_DEPTH];
    logic signed [COEF_W-1:0]   b_tap_reg  [NUM_DEPTH];
    logic signed [COEF_W-1:0]   a_tap_reg  [DEN_DEPTH];

    // Handshake decodes
    logic s_fire, sample_fire, num_wr, den_wr, out_load;
    logic [NUM_IDX_W-1:0] order_clamped;
    logic [DEN_IDX_W-1:0] den_idx;

    assign s_ready     = (state_reg == S_IDLE);
    assign s_fire      = s_valid && s_ready;
    assign sample_fire = s_fire && (s_command == CMD_SAMPLE);
    assign num_wr      = s_fire && (s_command == CMD_NUM_TAP) && (int'(s_tap_index) <= MAX_ORDER);
    assign den_wr      = s_fire && (s_command == CMD_DEN_TAP) && (int'(s_tap_index) < MAX_ORDER);
    assign out_load    = (state_reg == S_OUT) && (!m_valid_reg || m_ready);
    assign den_idx     = idx_reg[DEN_IDX_W-1:0];

    // Order zero runs as first order, anything above the maximum as the maximum
    always_comb begin
        if (order_reg == '0) begin
            order_clamped = NUM_IDX_W'(1);
        end else if (int'(order_reg) > MAX_ORDER) begin
            order_clamped = NUM_IDX_W'(MAX_ORDER);
        end else begin
            order_clamped = NUM_IDX_W'(order_reg);
        end
    end

    // Shared multiplier: feed-forward taps then feedback taps
    logic signed [COEF_W-1:0] mul_a;
    logic signed [OUT_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]  mul_p;

    always_comb begin
        if (state_reg == S_DEN) begin
            mul_a = a_tap_reg[den_idx];
            mul_b = y_hist_reg[den_idx];
        end else begin
            mul_a = b_tap_reg[idx_reg];
            mul_b = OUT_W'(x_hist_reg[idx_reg]);
        end
    end

    assign mul_p = mul_a * mul_b;

    // Rounded quotient and output saturation
    logic signed [QUOT_W-1:0] quot;
    logic signed [OUT_W-1:0]  y_sat;

    assign quot = QUOT_W'(acc_reg >>> ROUND_SHIFT);

    always_comb begin
        if (quot[QUOT_W-1:OUT_W-1] == '0 || quot[QUOT_W-1:OUT_W-1] == '1) begin
            y_sat = quot[OUT_W-1:0];
        end else begin
            y_sat = quot[QUOT_W-1] ? OUT_MIN : OUT_MAX;
        end
    end

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        acc_next      = acc_reg;
        prod_vld_next = 1'b0;
        prod_sub_next = prod_sub_reg;
        m_valid_next  = m_valid_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        // accumulate the product registered last cycle
        if (prod_vld_reg) begin
            acc_next = prod_sub_reg ? sat_addsub(acc_reg, prod_reg, 1'b1)
                                    : sat_addsub(acc_reg, prod_reg <<< NUM_SHIFT, 1'b0);
        end

        case (state_reg)
            S_IDLE: begin
                if (sample_fire) begin
                    acc_next   = '0;
                    idx_next   = '0;
                    n_next     = order_clamped;
                    state_next = S_NUM;
                end
            end
            S_NUM: begin
                prod_vld_next = 1'b1;
                prod_sub_next = 1'b0;
                if (idx_reg == n_reg) begin
                    idx_next   = '0;
                    state_next = S_DEN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DEN: begin
                prod_vld_next = 1'b1;
                prod_sub_next = 1'b1;
                if (idx_reg == n_reg - 1'b1) begin
                    state_next = S_DRAIN;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            S_DRAIN: begin
                state_next = S_RND;
            end
            S_RND: begin
                acc_next   = sat_addsub(acc_reg, ROUND_HALF, 1'b0);
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            order_reg    <= ORDER_W'(1);
            n_reg        <= NUM_IDX_W'(1);
            idx_reg      <= '0;
            prod_vld_reg <= 1'b0;
            prod_sub_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            n_reg        <= n_next;
            idx_reg      <= idx_next;
            prod_vld_reg <= prod_vld_next;
            prod_sub_reg <= prod_sub_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                order_reg <= cfg_wr_data;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        acc_reg  <= acc_next;
        prod_reg <= mul_p;
        if (out_load) begin
            m_filtered_reg <= y_sat;
        end
    end

    // Histories and taps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NUM_DEPTH; i++) begin
                x_hist_reg[i] <= '0;
                b_tap_reg[i]  <= '0;
            end
            for (int i = 0; i < DEN_DEPTH; i++) begin
                y_hist_reg[i] <= '0;
                a_tap_reg[i]  <= '0;
            end
        end else begin
            if (sample_fire) begin
                for (int i = NUM_DEPTH - 1; i > 0; i--) begin
                    x_hist_reg[i] <= x_hist_reg[i-1];
                end
                x_hist_reg[0] <= s_sample;
            end
            if (out_load) begin
                for (int i = DEN_DEPTH - 1; i > 0; i--) begin
                    y_hist_reg[i] <= y_hist_reg[i-1];
                end
                y_hist_reg[0] <= y_sat;
            end
            if (num_wr) begin
                b_tap_reg[NUM_IDX_W'(s_tap_index)] <= s_coefficient;
            end
            if (den_wr) begin
                a_tap_reg[DEN_IDX_W'(s_tap_index)] <= s_coefficient;
            end
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_filtered = m_filtered_reg;

    // Assertions
    `IIR_ASSERT_NEXT(a_sample_starts_mac, sample_fire, (state_reg == S_NUM) && (idx_reg == '0), "sample transaction did not start the MAC sequence")
    `IIR_ASSERT_NOW(a_num_idx_bound, state_reg == S_NUM, idx_reg <= n_reg, "feed-forward tap index past order")
    `IIR_ASSERT_NOW(a_prod_source, prod_vld_reg, ($past(state_reg) == S_NUM) || ($past(state_reg) == S_DEN), "product accumulated outside a MAC step")
    `IIR_ASSERT_NOW(a_result_from_out, $rose(m_valid_reg), $past(state_reg) == S_OUT, "result raised outside the output state")

endmodule

@@ tb/iir_lowpass_direct_form_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the direct-form-I IIR low-pass filter
// Streams tap writes and samples through the filter and predicts each output
// with a bit-exact fixed-point model kept in step with accepted transactions.
// The run covers several filter orders, out-of-range tap writes, the unused
// command, accumulator and output saturation, and random back-pressure.
// ----------------------------------------------------------------------------
module iir_lowpass_direct_form_tb;
    import iir_lp_pkg::*;

    localparam int CLK_HALF        = 4;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 215;
    localparam int DRAIN_CYCLES    = 2 * MAX_ORDER + 15;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int MAX_REPORTS     = 10;

    // Command code with no function in the block
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]           command;
        logic signed [SAMPLE_W-1:0] sample;
        logic [TAP_W-1:0]           tap_index;
        logic signed [COEF_W-1:0]   coefficient;
    } filter_cmd_t;

    // DUT signals; the inputs are known from time zero
    logic                       aclk          = 1'b0;
    logic                       aresetn       = 1'b0;
    logic                       cfg_wr_en     = 1'b0;
    logic [ORDER_W-1:0]         cfg_wr_data   = '0;
    logic                       s_valid       = 1'b0;
    logic                       s_ready;
    logic [CMD_W-1:0]           s_command     = '0;
    logic signed [SAMPLE_W-1:0] s_sample      = '0;
    logic [TAP_W-1:0]           s_tap_index   = '0;
    logic signed [COEF_W-1:0]   s_coefficient = '0;
    logic                       m_valid;
    logic                       m_ready       = 1'b0;
    logic signed [OUT_W-1:0]    m_filtered;

    // Filter state as the testbench sees it
    logic signed [SAMPLE_W-1:0] x_hist [NUM_DEPTH];
    logic signed [OUT_W-1:0]    y_hist [DEN_DEPTH];
    logic signed [COEF_W-1:0]   b_taps [NUM_DEPTH];
    logic signed [COEF_W-1:0]   a_taps [DEN_DEPTH];
    logic [ORDER_W-1:0]         model_order = 4'd1;

    filter_cmd_t             cmd_queue [$];
    logic signed [OUT_W-1:0] filtered_due [$];
    filter_cmd_t             cur_item;
    bit                      xfer_in      = 1'b0;
    int                      snd_idle_pct = 0;
    int                      rcv_idle_pct = 0;
    int                      error_count  = 0;
    int                      cycle_count  = 0;
    logic [ORDER_W-1:0]      phase_order [NUM_PHASES] =
        '{4'd8, 4'd1, 4'd0, 4'd15, 4'd3, 4'd8, 4'd5};

    iir_lowpass_direct_form i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_command     (s_command),
        .s_sample      (s_sample),
        .s_tap_index   (s_tap_index),
        .s_coefficient (s_coefficient),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_filtered    (m_filtered)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    // 64-bit add clamped at the signed limits
    function automatic longint sat_add64(longint a, longint b);
        logic [ACC_W:0] sum;
        sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            return sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end
        return sum[ACC_W-1:0];
    endfunction

    // Apply one accepted transaction to the filter state; samples yield an output
    function automatic void filter_step(filter_cmd_t c);
        int                      n;
        longint                  acc;
        longint                  p;
        logic signed [OUT_W-1:0] y;
        case (c.command)
            CMD_NUM_TAP: begin
                if (c.tap_index <= MAX_ORDER) b_taps[c.tap_index] = c.coefficient;
            end
            CMD_DEN_TAP: begin
                if (c.tap_index < DEN_DEPTH) a_taps[c.tap_index] = c.coefficient;
            end
            CMD_SAMPLE: begin
                // order 0 behaves as 1, anything above the maximum as the maximum
                n = (model_order == 0) ? 1 :
                    (model_order > MAX_ORDER) ? MAX_ORDER : int'(model_order);
                for (int i = MAX_ORDER; i > 0; i--) x_hist[i] = x_hist[i-1];
                x_hist[0] = c.sample;
                acc = 0;
                // feed-forward terms, aligned to Q.38
                for (int i = 0; i <= n; i++) begin
                    p = longint'(b_taps[i]) * longint'(x_hist[i]);
                    acc = sat_add64(acc, p * 16384);
                end
                // feedback terms
                for (int i = 0; i < n; i++) begin
                    p = longint'(a_taps[i]) * longint'(y_hist[i]);
                    acc = sat_add64(acc, -p);
                end
                // round half up to Q.14, then clamp to 32 bits
                acc = sat_add64(acc, longint'(1) <<< (ROUND_SHIFT - 1));
                acc = acc >>> ROUND_SHIFT;
                if (acc > longint'(32'sh7fffffff)) y = 32'sh7fffffff;
                else if (acc < longint'(32'sh80000000)) y = 32'sh80000000;
                else y = acc[OUT_W-1:0];
                for (int i = DEN_DEPTH - 1; i > 0; i--) y_hist[i] = y_hist[i-1];
                y_hist[0] = y;
                filtered_due.push_back(y);
            end
            default: ;
        endcase
    endfunction

    function automatic void queue_cmd(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] smp,
                                      logic [TAP_W-1:0] idx, logic [COEF_W-1:0] coef);
        filter_cmd_t c;
        c.command     = cmd;
        c.sample      = smp;
        c.tap_index   = idx;
        c.coefficient = coef;
        cmd_queue.push_back(c);
    endfunction

    // Mostly modest taps so the filter does something useful, with extremes mixed in
    function automatic logic [COEF_W-1:0] pick_coef(bit feedback);
        int unsigned lim;
        lim = feedback ? (1 << 21) : (1 << 23);
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            1, 2:    return $urandom;
            default: return $urandom_range(0, 2 * lim) - lim;
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Input driver: present the next queued transaction once the last one is taken
    always @(negedge aclk) begin
        if (!s_valid || xfer_in) begin
            xfer_in = 1'b0;
            if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                cur_item = cmd_queue.pop_front();
                s_valid       <= 1'b1;
                s_command     <= cur_item.command;
                s_sample      <= cur_item.sample;
                s_tap_index   <= cur_item.tap_index;
                s_coefficient <= cur_item.coefficient;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Accepted input transactions update the prediction
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            xfer_in = 1'b1;
            filter_step(cur_item);
        end
    end

    // Result back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end

    // Output monitor
    always @(posedge aclk) begin
        logic signed [OUT_W-1:0] want;
        if (aresetn && m_valid && m_ready) begin
            if (filtered_due.size() == 0) begin
                if (error_count < MAX_REPORTS) begin
                    $display("unexpected output: got %0d (0x%08h)", m_filtered, m_filtered);
                end
                error_count++;
            end else begin
                want = filtered_due.pop_front();
                if (m_filtered !== want) begin
                    if (error_count < MAX_REPORTS) begin
                        $display("filtered mismatch: expected %0d (0x%08h), got %0d (0x%08h)",
                                 want, want, m_filtered, m_filtered);
                    end
                    error_count++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("iir_lowpass_direct_form test failed");
            $finish;
        end
    end

    // Stimulus sequencing
    initial begin
        int               left;
        int               k;
        int               burst;
        logic [CMD_W-1:0] cmd;
        logic [TAP_W-1:0] idx;
        foreach (x_hist[i]) x_hist[i] = '0;
        foreach (b_taps[i]) b_taps[i] = '0;
        foreach (y_hist[i]) y_hist[i] = '0;
        foreach (a_taps[i]) a_taps[i] = '0;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            // sender busy and receiver slow, then swapped, then free running
            if (ph < 3) begin
                snd_idle_pct = 21;
                rcv_idle_pct = 81;
            end else if (ph < 5) begin
                snd_idle_pct = 81;
                rcv_idle_pct = 21;
            end else begin
                snd_idle_pct = 0;
                rcv_idle_pct = 0;
            end

            // order change while the filter is idle
            @(negedge aclk);
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= phase_order[ph];
            model_order = phase_order[ph];
            @(negedge aclk);
            cfg_wr_en <= 1'b0;

            if (ph == 0) begin
                // extreme taps, plus writes past the end of each tap bank
                queue_cmd(CMD_NUM_TAP, '0, 4'd0, 32'h7fffffff);
                queue_cmd(CMD_NUM_TAP, '0, 4'd8, 32'h80000000);
                queue_cmd(CMD_NUM_TAP, '0, 4'd9, $urandom);
                queue_cmd(CMD_NUM_TAP, '1, 4'd15, $urandom);
                queue_cmd(CMD_DEN_TAP, '0, 4'd0, 32'h7fffffff);
                queue_cmd(CMD_DEN_TAP, '0, 4'd7, 32'h80000000);
                queue_cmd(CMD_DEN_TAP, '0, 4'd8, $urandom);
                queue_cmd(CMD_DEN_TAP, '1, 4'd15, $urandom);
                queue_cmd(CMD_UNUSED, '1, 4'd15, 32'hffffffff);
                queue_cmd(CMD_SAMPLE, 16'h7fff, '0, '0);
                queue_cmd(CMD_SAMPLE, 16'h8000, '1, '1);
                queue_cmd(CMD_SAMPLE, 16'h0000, '0, '0);
                queue_cmd(CMD_SAMPLE, 16'hffff, '0, '0);
                queue_cmd(CMD_SAMPLE, 16'h0001, '0, '0);
                queue_cmd(CMD_SAMPLE, 16'h8000, '0, '0);
                // more full-scale taps to drive the accumulator into its limits
                for (int i = 1; i <= 3; i++) begin
                    queue_cmd(CMD_NUM_TAP, '0, TAP_W'(i), 32'h7fffffff);
                end
                queue_cmd(CMD_SAMPLE, 16'h7fff, '0, '0);
                queue_cmd(CMD_SAMPLE, 16'h7fff, '0, '0);
                queue_cmd(CMD_SAMPLE, 16'h8000, '0, '0);
                queue_cmd(CMD_SAMPLE, 16'h8000, '0, '0);
            end else begin
                // tap updates followed by sample bursts, with some noise between
                left = ITEMS_PER_PHASE;
                while (left > 0) begin
                    if ($urandom_range(0, 4) == 0) begin
                        cmd = CMD_W'($urandom_range(0, 3));
                        idx = TAP_W'($urandom_range(0, 15));
                        queue_cmd(cmd, SAMPLE_W'($urandom), idx, $urandom);
                        if (cmd == CMD_SAMPLE || (cmd == CMD_NUM_TAP && idx <= MAX_ORDER) ||
                            (cmd == CMD_DEN_TAP && idx < DEN_DEPTH)) begin
                            left--;
                        end
                    end else begin
                        k = $urandom_range(1, 5);
                        repeat (k) begin
                            if ($urandom_range(0, 1)) begin
                                queue_cmd(CMD_NUM_TAP, SAMPLE_W'($urandom),
                                          TAP_W'($urandom_range(0, MAX_ORDER)),
                                          pick_coef(1'b0));
                            end else begin
                                queue_cmd(CMD_DEN_TAP, SAMPLE_W'($urandom),
                                          TAP_W'($urandom_range(0, DEN_DEPTH - 1)),
                                          pick_coef(1'b1));
                            end
                        end
                        burst = $urandom_range(4, 24);
                        repeat (burst) queue_cmd(CMD_SAMPLE, pick_sample(),
                                                 TAP_W'($urandom), $urandom);
                        left -= k + burst;
                    end
                end
            end

            // drain: everything sent, every output seen, then let tap writes settle
            while (cmd_queue.size() != 0 || s_valid || filtered_due.size() != 0) begin
                @(posedge aclk);
            end
            repeat (DRAIN_CYCLES) @(posedge aclk);
        end

        if (error_count == 0 && filtered_due.size() == 0) begin
            $display("iir_lowpass_direct_form test passed");
        end else begin
            $display("iir_lowpass_direct_form test failed");
        end
        $finish;
    end

endmodule
